FILE: rtl/wsfb_pkg.sv
package wsfb_pkg;

   localparam int LEN_W  = 63;
   localparam int KEY_W  = 32;
   localparam int BYTE_W = 8;
   localparam int IDX_W  = 4;

   // Request commands.
   localparam logic CMD_BEGIN = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   // Byte address of the key register.
   localparam logic [2:0] REG_KEY_ADDR = 3'd0;

   // Kind of work that the back end carries out for one queue entry.
   localparam logic [1:0] KIND_HDR  = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   localparam logic [KEY_W-1:0]  KEY_RESET = 32'h1234_5678;
   localparam logic [BYTE_W-1:0] FIN_BIT   = 8'h80;
   localparam logic [6:0]        LEN7_16   = 7'd126;
   localparam logic [6:0]        LEN7_64   = 7'd127;
   localparam logic [LEN_W-1:0]  LEN7_MAX  = 63'd125;
   localparam logic [LEN_W-1:0]  LEN16_MAX = 63'h0000_0000_0000_FFFF;

   // Number of extended length bytes for each length form, then key and fixed header byte counts.
   localparam logic [IDX_W-1:0] EXT_NONE  = 4'd0;
   localparam logic [IDX_W-1:0] EXT_16    = 4'd2;
   localparam logic [IDX_W-1:0] EXT_64    = 4'd8;
   localparam logic [IDX_W-1:0] KEY_BYTES = 4'd4;
   localparam logic [IDX_W-1:0] FIXED_HDR = 4'd2;

   typedef struct packed {
      logic [1:0]        kind;
      logic [3:0]        opcode;
      logic              mask;
      logic [LEN_W-1:0]  len;
      logic [IDX_W-1:0]  ext_cnt;
      logic [IDX_W-1:0]  last_idx;
      logic [KEY_W-1:0]  key;
      logic [BYTE_W-1:0] data;
      logic              fend;
   } entry_type;

   // Key byte 0 sits in the most significant byte.
   function automatic logic [BYTE_W-1:0] key_byte(input logic [KEY_W-1:0] key,
                                                  input logic [1:0] pos);
      logic [BYTE_W-1:0] b;
      case (pos)
         2'd0: b = key[31:24];
         2'd1: b = key[23:16];
         2'd2: b = key[15:8];
         2'd3: b = key[7:0];
         default: b = key[7:0];
      endcase
      return b;
   endfunction

endpackage

FILE: rtl/websocket_frame_builder.sv
// Channel  Direction  Handshake              Beat content
// req      in         req_valid/req_stall    cmd, opcode, mask, length, data byte
// rsp      out        rsp_valid/rsp_stall    frame byte, last_of_run, frame_end, error
// csr      in/out     APB, pready tied high  masking key at byte address 0
//
// A payload item gives one beat, a begin item 2 to 14 header beats, one per unstalled cycle.
// The input side takes one item per cycle until the entry queue (QUEUE_DEPTH) fills;
// header runs drain it at one beat a cycle and payload at one byte a cycle, when not stalled.
// The output beat sits in a register; a stall holds it while the front keeps queueing.
// Synchronous reset clears frame state, the queue and the output; the key returns to 0x12345678.
module websocket_frame_builder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [3:0]  req_frame_opcode,
   input  logic        req_mask_enable,
   input  logic [62:0] req_frame_length,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run,
   output logic        rsp_frame_end,
   output logic        rsp_error,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import wsfb_pkg::*;

   logic [KEY_W-1:0] key_ff;
   logic             key_sel;
   logic             q_full, q_push, q_empty, q_pop;
   entry_type        q_entry, q_head;

   assign csr_pready = 1'b1;
   assign key_sel    = (csr_paddr[2] == REG_KEY_ADDR[2]);
   assign csr_prdata = key_sel ? key_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= KEY_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && key_sel) begin
         key_ff <= csr_pwdata;
      end
   end

   wsfb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_frame_opcode (req_frame_opcode),
      .req_mask_enable  (req_mask_enable),
      .req_frame_length (req_frame_length),
      .req_data_byte    (req_data_byte),
      .frame_key        (key_ff),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (q_entry)
   );

   wsfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (q_head)
   );

   wsfb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_error       (rsp_error)
   );

endmodule

FILE: rtl/wsfb_front.sv
module wsfb_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_cmd,
   input  logic [3:0]                req_frame_opcode,
   input  logic                      req_mask_enable,
   input  logic [wsfb_pkg::LEN_W-1:0] req_frame_length,
   input  logic [7:0]                req_data_byte,
   input  logic [wsfb_pkg::KEY_W-1:0] frame_key,
   input  logic                      q_full,
   output logic                      q_push,
   output wsfb_pkg::entry_type       q_entry
);
   import wsfb_pkg::*;

   logic [1:0]       key_pos_ff, key_pos_in;
   logic             mask_act_ff, mask_act_in;
   logic [LEN_W-1:0] remain_ff, remain_in;
   logic             accept;
   logic [IDX_W-1:0] key_cnt;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept;

   always_comb begin
      key_pos_in  = key_pos_ff;
      mask_act_in = mask_act_ff;
      remain_in   = remain_ff;
      key_cnt     = req_mask_enable ? KEY_BYTES : EXT_NONE;

      q_entry          = '0;
      q_entry.opcode   = req_frame_opcode;
      q_entry.mask     = req_mask_enable;
      q_entry.len      = req_frame_length;
      q_entry.key      = frame_key;

      if (req_cmd == CMD_BEGIN) begin
         q_entry.kind = KIND_HDR;
         if (req_frame_length <= LEN7_MAX) begin
            q_entry.ext_cnt = EXT_NONE;
         end else if (req_frame_length <= LEN16_MAX) begin
            q_entry.ext_cnt = EXT_16;
         end else begin
            q_entry.ext_cnt = EXT_64;
         end
         q_entry.last_idx = q_entry.ext_cnt + key_cnt + 4'd1;
         q_entry.fend     = (req_frame_length == '0);
         key_pos_in  = 2'd0;
         mask_act_in = req_mask_enable;
         remain_in   = req_frame_length;
      end else if (remain_ff == '0) begin
         q_entry.kind = KIND_ERR;
      end else begin
         q_entry.kind = KIND_DATA;
         q_entry.data = req_data_byte ^
                        (mask_act_ff ? key_byte(frame_key, key_pos_ff) : 8'h00);
         q_entry.fend = (remain_ff == LEN_W'(1));
         key_pos_in   = key_pos_ff + 2'd1;
         remain_in    = remain_ff - LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_pos_ff  <= 2'd0;
         mask_act_ff <= 1'b0;
         remain_ff   <= '0;
      end else if (accept) begin
         key_pos_ff  <= key_pos_in;
         mask_act_ff <= mask_act_in;
         remain_ff   <= remain_in;
      end
   end

endmodule

FILE: rtl/wsfb_queue.sv
module wsfb_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  wsfb_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output wsfb_pkg::entry_type head
);
   import wsfb_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_pop;

   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);
   assign head   = slots_ff[rd_ptr_ff];
   assign do_pop = pop && !empty;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

FILE: rtl/wsfb_back.sv
module wsfb_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  wsfb_pkg::entry_type q_head,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_last_of_run,
   output logic                rsp_frame_end,
   output logic                rsp_error
);
   import wsfb_pkg::*;

   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              valid_ff;
   logic [7:0]        byte_ff, byte_in;
   logic              last_ff, fend_ff, err_ff;
   logic              load, emit, is_last;
   logic [IDX_W-1:0]  j, kpos, sel;
   logic [6:0]        len7;
   logic [63:0]       len64;

   // The output register takes a new beat whenever it is empty or being drained and the queue has an entry.
   assign load    = !valid_ff || !rsp_stall;
   assign emit    = load && !q_empty;
   assign is_last = (idx_ff == q_head.last_idx);
   assign q_pop   = emit && is_last;

   always_comb begin
      j     = idx_ff - FIXED_HDR;
      kpos  = j - q_head.ext_cnt;
      sel   = q_head.ext_cnt - j - 4'd1;
      len64 = {1'b0, q_head.len};
      idx_in = is_last ? '0 : idx_ff + 4'd1;
      case (q_head.ext_cnt)
         EXT_16:  len7 = LEN7_16;
         EXT_64:  len7 = LEN7_64;
         default: len7 = q_head.len[6:0];
      endcase
      case (q_head.kind)
         KIND_HDR: begin
            if (idx_ff == 4'd0) begin
               byte_in = FIN_BIT | {4'h0, q_head.opcode};
            end else if (idx_ff == 4'd1) begin
               byte_in = {q_head.mask, len7};
            end else if (j < q_head.ext_cnt) begin
               byte_in = len64[{sel[2:0], 3'b000} +: 8];
            end else begin
               byte_in = key_byte(q_head.key, kpos[1:0]);
            end
         end
         KIND_DATA: byte_in = q_head.data;
         default:   byte_in = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= !q_empty;
         if (emit) begin
            idx_ff <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff <= byte_in;
         last_ff <= is_last;
         fend_ff <= is_last && q_head.fend;
         err_ff  <= (q_head.kind == KIND_ERR);
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_frame_end   = fend_ff;
   assign rsp_error       = err_ff;

endmodule

FILE: rtl/wsfb_checker.sv
module wsfb_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_of_run,
   input logic       rsp_frame_end,
   input logic       rsp_error
);

   // A stalled beat keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) &&
      $stable(rsp_last_of_run) && $stable(rsp_frame_end) && $stable(rsp_error))
      else $error("stalled result beat changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // An error beat stands alone, carries a zero byte and never closes a frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_last_of_run && !rsp_frame_end && rsp_out_byte == 8'h00)
      else $error("malformed error beat");

   // The final byte of a frame is always the final beat of its item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_last_of_run && !rsp_error)
      else $error("frame end inside a run");

endmodule

bind websocket_frame_builder wsfb_checker u_wsfb_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_last_of_run (rsp_last_of_run),
   .rsp_frame_end   (rsp_frame_end),
   .rsp_error       (rsp_error)
);
